FILE: rtl/mrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrd_pkg;

   // Fixed field widths of the request and response
   localparam int WORD_W   = 32;
   localparam int MSG_WORDS = 4;
   localparam int MSG_W    = WORD_W * MSG_WORDS;
   localparam int FIELD_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [1:0] {
      REQ_SEND    = 2'd0,
      REQ_URGENT  = 2'd1,
      REQ_RECEIVE = 2'd2,
      REQ_PEEK    = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/mrd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mrd_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/message_ring_deque.sv
`timescale 1ns / 1ps
`default_nettype none

// The response strobes in the cycle after the request is taken.
// Throughput: one request per cycle; busy never rises, the slot memory
// takes one write or one read per request on its single ports.
// Reset clears pointers, occupancy, peak and all counters and sets depth to 16
// (or MAX_SLOTS if smaller); slot contents are not cleared.
// The receiver cannot stall: each response is valid for exactly one cycle.
module message_ring_deque #(
   parameter int MAX_SLOTS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_type,
   input  wire logic [mrd_pkg::WORD_W-1:0]     req_msg_word0,
   input  wire logic [mrd_pkg::WORD_W-1:0]     req_msg_word1,
   input  wire logic [mrd_pkg::WORD_W-1:0]     req_msg_word2,
   input  wire logic [mrd_pkg::WORD_W-1:0]     req_msg_word3,
   // configuration
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mrd_pkg::FIELD_W-1:0]    csr_queue_depth,
   // response
   output logic                                rsp_valid,
   output logic [mrd_pkg::STATUS_W-1:0]        rsp_status,
   output logic [mrd_pkg::WORD_W-1:0]          rsp_data_word0,
   output logic [mrd_pkg::WORD_W-1:0]          rsp_data_word1,
   output logic [mrd_pkg::WORD_W-1:0]          rsp_data_word2,
   output logic [mrd_pkg::WORD_W-1:0]          rsp_data_word3,
   output logic [mrd_pkg::FIELD_W-1:0]         rsp_msg_count,
   output logic [mrd_pkg::FIELD_W-1:0]         rsp_free_slots,
   output logic [mrd_pkg::FIELD_W-1:0]         rsp_high_water,
   output logic [mrd_pkg::WORD_W-1:0]          rsp_sent_total,
   output logic [mrd_pkg::WORD_W-1:0]          rsp_received_total,
   output logic [mrd_pkg::WORD_W-1:0]          rsp_overflow_total
);

   import mrd_pkg::*;

   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int DEPTH_RST = (16 > MAX_SLOTS) ? MAX_SLOTS : 16;

   logic [IDX_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in, peak_ff, peak_in, depth_ff, depth_in;
   logic [WORD_W-1:0] sent_ff, sent_in, recv_ff, recv_in, ovf_ff, ovf_in;
   logic              rsp_valid_ff;
   status_type        status_ff, status_in;
   logic              read_ok_ff, read_ok_in;

   logic              accept;
   logic              csr_write;
   req_kind_type      kind;
   logic [CNT_W-1:0]  depth_clamp;
   logic [CNT_W-1:0]  head_plus, tail_plus;
   logic [IDX_W-1:0]  head_next, tail_next, head_back;
   logic              full, empty;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [MSG_W-1:0]  wr_data, rd_data;

   // Hold off a depth write while a request is being taken
   assign busy      = 1'b0;
   assign csr_ready = ~start;
   assign accept    = start & ~busy;
   assign csr_write = csr_valid & csr_ready;
   assign kind      = req_kind_type'(req_type);

   assign full  = (count_ff >= depth_ff);
   assign empty = (count_ff == '0);

   // Wrap pointers at the configured depth
   assign head_plus = CNT_W'(head_ff) + CNT_W'(1);
   assign tail_plus = CNT_W'(tail_ff) + CNT_W'(1);
   assign head_next = (head_plus >= depth_ff) ? '0 : IDX_W'(head_plus);
   assign tail_next = (tail_plus >= depth_ff) ? '0 : IDX_W'(tail_plus);
   assign head_back = (head_ff == '0) ? IDX_W'(depth_ff - CNT_W'(1))
                                      : head_ff - IDX_W'(1);

   // Clamp the written depth into 1 .. MAX_SLOTS
   always_comb begin
      if (csr_queue_depth == '0) begin
         depth_clamp = CNT_W'(1);
      end else if (int'(csr_queue_depth) > MAX_SLOTS) begin
         depth_clamp = CNT_W'(MAX_SLOTS);
      end else begin
         depth_clamp = CNT_W'(csr_queue_depth);
      end
   end

   // Decide the request and the next state
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      peak_in    = peak_ff;
      depth_in   = depth_ff;
      sent_in    = sent_ff;
      recv_in    = recv_ff;
      ovf_in     = ovf_ff;
      status_in  = STATUS_DONE;
      read_ok_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = tail_ff;

      if (accept) begin
         unique case (kind)
            REQ_SEND, REQ_URGENT: begin
               if (full) begin
                  status_in = STATUS_FULL;
                  ovf_in    = ovf_ff + WORD_W'(1);
               end else begin
                  wr_en = 1'b1;
                  if (kind == REQ_URGENT) begin
                     head_in = head_back;
                     wr_addr = head_back;
                  end else begin
                     tail_in = tail_next;
                     wr_addr = tail_ff;
                  end
                  count_in = count_ff + CNT_W'(1);
                  if (count_in > peak_ff) begin
                     peak_in = count_in;
                  end
                  sent_in = sent_ff + WORD_W'(1);
               end
            end
            REQ_RECEIVE, REQ_PEEK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  read_ok_in = 1'b1;
                  if (kind == REQ_RECEIVE) begin
                     head_in  = head_next;
                     count_in = count_ff - CNT_W'(1);
                     recv_in  = recv_ff + WORD_W'(1);
                  end
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end else if (csr_write && empty) begin
         depth_in = depth_clamp;
         head_in  = '0;
         tail_in  = '0;
      end
   end

   assign wr_data = {req_msg_word3, req_msg_word2, req_msg_word1, req_msg_word0};

   mrd_ram #(
      .WIDTH (MSG_W),
      .DEPTH (MAX_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (read_ok_in),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // Hold state and the registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         peak_ff      <= '0;
         depth_ff     <= CNT_W'(DEPTH_RST);
         sent_ff      <= '0;
         recv_ff      <= '0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_DONE;
         read_ok_ff   <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         depth_ff     <= depth_in;
         sent_ff      <= sent_in;
         recv_ff      <= recv_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= accept;
         status_ff    <= status_in;
         read_ok_ff   <= read_ok_in;
      end
   end

   // Drive the response; data is zero unless a read succeeded
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_data_word0     = read_ok_ff ? rd_data[0*WORD_W +: WORD_W] : '0;
   assign rsp_data_word1     = read_ok_ff ? rd_data[1*WORD_W +: WORD_W] : '0;
   assign rsp_data_word2     = read_ok_ff ? rd_data[2*WORD_W +: WORD_W] : '0;
   assign rsp_data_word3     = read_ok_ff ? rd_data[3*WORD_W +: WORD_W] : '0;
   assign rsp_msg_count      = FIELD_W'(count_ff);
   assign rsp_free_slots     = FIELD_W'(depth_ff - count_ff);
   assign rsp_high_water     = FIELD_W'(peak_ff);
   assign rsp_sent_total     = sent_ff;
   assign rsp_received_total = recv_ff;
   assign rsp_overflow_total = ovf_ff;

endmodule

`default_nettype wire
